@@ rtl/letwa_pkg.sv @@
// Shared types and constants for the leading-edge time-of-arrival and waveform averager.
package letwa_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int TIME_BITS   = 32;
    localparam int SUM_BITS    = 32;
    localparam int COUNT_BITS  = 16;
    localparam int INDEX_BITS  = 12;
    localparam int REQ_BITS    = 2;
    localparam int AVG_BITS    = 16;

    // Request codes of the input word.
    localparam logic [REQ_BITS-1:0] REQ_SAMPLE = 2'd0;
    localparam logic [REQ_BITS-1:0] REQ_READ   = 2'd1;
    localparam logic [REQ_BITS-1:0] REQ_CLEAR  = 2'd2;

    // Result kinds.
    localparam logic KIND_TOA = 1'b0;
    localparam logic KIND_AVG = 1'b1;

    // Register index of the threshold on the configuration port.
    localparam logic REG_THRESHOLD = 1'b0;

    localparam logic signed [SAMPLE_BITS-1:0] THRESH_RESET = 16'sd2;
    localparam logic [COUNT_BITS-1:0]          COUNT_MAX    = 16'hFFFF;

    // Saturation bounds of the average, as quotient magnitudes and as results.
    localparam logic [SUM_BITS-1:0] QUOT_POS_LIMIT = 32'd32767;
    localparam logic [SUM_BITS-1:0] QUOT_NEG_LIMIT = 32'd32768;
    localparam logic [AVG_BITS-1:0] AVG_POS_SAT    = 16'h7FFF;
    localparam logic [AVG_BITS-1:0] AVG_NEG_SAT    = 16'h8000;

    localparam int DIV_STEPS    = SUM_BITS;
    localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);

    typedef struct packed {
        logic smp_fire;
        logic rd_fire;
        logic clr_fire;
        logic div_load;
        logic div_step;
        logic avg_push;
    } letwa_cmd_t;

    typedef struct packed {
        logic rbuf_full;
    } letwa_status_t;

    typedef struct packed {
        logic                  kind;
        logic                  edge_found;
        logic [TIME_BITS-1:0]  arrival_time;
        logic [AVG_BITS-1:0]   average_value;
        logic                  average_valid;
        logic [COUNT_BITS-1:0] waveforms_seen;
    } letwa_res_t;

endpackage

@@ rtl/letwa_ram.sv @@
// Generic simple dual-port RAM with one write port and one registered read port.
module letwa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // A read at the address being written returns the old contents.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/letwa_rbuf.sv @@
// Two-entry result buffer: an output register backed by a skid register.
module letwa_rbuf (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  letwa_pkg::letwa_res_t push_data,
    input  logic                  m_ready,
    output logic                  m_valid,
    output letwa_pkg::letwa_res_t head,
    output logic                  full
);

    logic                  head_full_reg, head_full_next;
    logic                  skid_full_reg, skid_full_next;
    letwa_pkg::letwa_res_t head_reg, head_next;
    letwa_pkg::letwa_res_t skid_reg, skid_next;
    logic                  pop;

    assign pop     = head_full_reg && m_ready;
    assign m_valid = head_full_reg;
    assign head    = head_reg;
    assign full    = skid_full_reg;

    always_comb begin
        head_full_next = head_full_reg;
        skid_full_next = skid_full_reg;
        head_next      = head_reg;
        skid_next      = skid_reg;
        if (pop) begin
            if (skid_full_reg) begin
                head_next = skid_reg;
                if (push) begin
                    skid_next = push_data;
                end else begin
                    skid_full_next = 1'b0;
                end
            end else if (push) begin
                head_next = push_data;
            end else begin
                head_full_next = 1'b0;
            end
        end else if (push) begin
            if (!head_full_reg) begin
                head_next      = push_data;
                head_full_next = 1'b1;
            end else begin
                skid_next      = push_data;
                skid_full_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_full_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end else begin
            head_full_reg <= head_full_next;
            skid_full_reg <= skid_full_next;
        end
    end

    always_ff @(posedge aclk) begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

    a_skid_implies_head: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_full_reg |-> head_full_reg)
        else $error("skid entry held while output register is empty");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push && skid_full_reg |-> pop)
        else $error("result pushed into a full buffer");

endmodule

@@ rtl/letwa_ctrl.sv @@
// Controller state machine: input acceptance, readout sequencing and divider stepping.
module letwa_ctrl (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    input  logic [letwa_pkg::REQ_BITS-1:0]     req_type,
    input  letwa_pkg::letwa_status_t           status,
    output logic                               s_ready,
    output letwa_pkg::letwa_cmd_t              cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_FETCH = 2'd1;
    localparam logic [1:0] S_DIV   = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]                         state_reg, state_next;
    logic [letwa_pkg::DIV_CNT_BITS-1:0] step_reg, step_next;
    logic                               fire;

    assign s_ready = (state_reg == S_IDLE) && !status.rbuf_full;
    assign fire    = s_valid && s_ready;

    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        cmd          = '0;
        cmd.smp_fire = fire && (req_type == letwa_pkg::REQ_SAMPLE);
        cmd.rd_fire  = fire && (req_type == letwa_pkg::REQ_READ);
        cmd.clr_fire = fire && (req_type == letwa_pkg::REQ_CLEAR);
        unique case (state_reg)
            S_IDLE: begin
                if (cmd.rd_fire) begin
                    state_next = S_FETCH;
                end
            end
            S_FETCH: begin
                // Sum word is on the RAM output now; load the divider.
                cmd.div_load = 1'b1;
                step_next    = '0;
                state_next   = S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == letwa_pkg::DIV_CNT_BITS'(letwa_pkg::DIV_STEPS - 1)) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                cmd.avg_push = 1'b1;
                state_next   = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // No input is taken during a readout, so the buffer must have room at its end.
    a_done_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DONE |-> !status.rbuf_full)
        else $error("readout finished with no room for its result");

    a_read_starts_fetch: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rd_fire |=> (state_reg == S_FETCH) && !s_ready)
        else $error("readout accepted but sequence did not start");

endmodule

@@ rtl/letwa_dpath.sv @@
// Datapath: crossing detection, sum store with read-modify-write, and serial divider.
module letwa_dpath #(
    parameter int MAX_SAMPLES = 4096
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  letwa_pkg::letwa_cmd_t                      cmd,
    input  logic signed [letwa_pkg::SAMPLE_BITS-1:0]   threshold,
    input  logic signed [letwa_pkg::SAMPLE_BITS-1:0]   sample_value,
    input  logic [letwa_pkg::TIME_BITS-1:0]            sample_time,
    input  logic                                       last_sample,
    input  logic [letwa_pkg::INDEX_BITS-1:0]           read_index,
    output logic                                       res_push,
    output letwa_pkg::letwa_res_t                      res_data
);

    localparam int AW = $clog2(MAX_SAMPLES);
    localparam int PW = $clog2(MAX_SAMPLES + 1);
    localparam int SB = letwa_pkg::SAMPLE_BITS;
    localparam int WB = letwa_pkg::SUM_BITS;
    localparam int CB = letwa_pkg::COUNT_BITS;
    localparam int TB = letwa_pkg::TIME_BITS;
    localparam logic [PW-1:0] POS_MAX = PW'(MAX_SAMPLES);

    // Waveform and averaging state.
    logic [PW-1:0] position_reg, position_next;
    logic [PW-1:0] avg_len_reg, avg_len_next;
    logic          length_fixed_reg, length_fixed_next;
    logic          crossing_seen_reg, crossing_seen_next;
    logic [TB-1:0] crossing_time_reg, crossing_time_next;
    logic [CB-1:0] count_reg, count_next;

    // Accumulate stage, write forwarding and readout.
    logic          s1_valid_reg, s1_valid_next;
    logic          s1_first_reg;
    logic [AW-1:0] s1_addr_reg;
    logic [WB-1:0] s1_value_reg;
    logic          fwd_hit_reg, fwd_hit_next;
    logic [WB-1:0] fwd_data_reg;
    logic          rd_valid_reg, rd_valid_next;

    // Divider.
    logic [WB-1:0] dvd_reg, dvd_next;
    logic [CB-1:0] rem_reg, rem_next;
    logic          neg_reg, neg_next;

    logic          mem_re, mem_we;
    logic [AW-1:0] mem_raddr, mem_waddr;
    logic [WB-1:0] mem_wdata, mem_rdata, old_sum;

    logic          cross_now, seen_f, found, do_sum;
    logic [TB-1:0] time_f;
    logic [PW-1:0] limit, pos_inc;
    logic [CB-1:0] count_inc;
    logic [WB-1:0] sample_ext;
    logic [CB+1:0] trial;
    logic          trial_ge;
    logic [letwa_pkg::AVG_BITS-1:0] avg_value;

    assign sample_ext = {{(WB - SB){sample_value[SB-1]}}, sample_value};

    // Sum store.
    assign mem_re    = cmd.smp_fire || cmd.rd_fire;
    assign mem_raddr = cmd.rd_fire ? AW'(read_index) : position_reg[AW-1:0];
    assign mem_we    = s1_valid_reg;
    assign mem_waddr = s1_addr_reg;
    assign old_sum   = fwd_hit_reg ? fwd_data_reg : mem_rdata;
    // The first waveform after reset or clear writes each entry it owns before any
    // valid readout, so it overwrites instead of adding and no clearing sweep is run.
    assign mem_wdata = s1_first_reg ? s1_value_reg : old_sum + s1_value_reg;

    letwa_ram #(
        .WIDTH (WB),
        .DEPTH (MAX_SAMPLES)
    ) u_sum_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Leading edge and position bookkeeping for a sample word.
    assign cross_now = !crossing_seen_reg && (sample_value >= threshold);
    assign seen_f    = crossing_seen_reg || cross_now;
    assign time_f    = cross_now ? sample_time : crossing_time_reg;
    assign found     = seen_f && (time_f != '0);
    assign limit     = length_fixed_reg ? avg_len_reg : POS_MAX;
    assign do_sum    = (position_reg < limit) && (position_reg < POS_MAX)
                       && (count_reg != letwa_pkg::COUNT_MAX);
    assign pos_inc   = (position_reg < POS_MAX) ? position_reg + PW'(1) : position_reg;
    assign count_inc = (count_reg != letwa_pkg::COUNT_MAX) ? count_reg + CB'(1) : count_reg;

    always_comb begin
        position_next      = position_reg;
        avg_len_next       = avg_len_reg;
        length_fixed_next  = length_fixed_reg;
        crossing_seen_next = crossing_seen_reg;
        crossing_time_next = crossing_time_reg;
        count_next         = count_reg;
        if (cmd.clr_fire) begin
            position_next      = '0;
            avg_len_next       = '0;
            length_fixed_next  = 1'b0;
            crossing_seen_next = 1'b0;
            crossing_time_next = '0;
            count_next         = '0;
        end else if (cmd.smp_fire) begin
            if (last_sample) begin
                position_next      = '0;
                crossing_seen_next = 1'b0;
                crossing_time_next = '0;
                count_next         = count_inc;
                if (!length_fixed_reg) begin
                    avg_len_next      = pos_inc;
                    length_fixed_next = 1'b1;
                end
            end else begin
                position_next      = pos_inc;
                crossing_seen_next = seen_f;
                crossing_time_next = time_f;
            end
        end
    end

    assign s1_valid_next = cmd.smp_fire && do_sum;
    assign fwd_hit_next  = mem_re && mem_we && (mem_raddr == mem_waddr);
    assign rd_valid_next = cmd.rd_fire ?
        ((count_reg != '0) && length_fixed_reg &&
         (32'(read_index) < 32'(avg_len_reg)) && (32'(read_index) < 32'(MAX_SAMPLES)))
        : rd_valid_reg;

    // Restoring division of the sum magnitude by the waveform count, one bit a step.
    assign trial    = {1'b0, rem_reg, dvd_reg[WB-1]} - {2'b00, count_reg};
    assign trial_ge = !trial[CB+1];

    always_comb begin
        dvd_next = dvd_reg;
        rem_next = rem_reg;
        neg_next = neg_reg;
        if (cmd.div_load) begin
            neg_next = old_sum[WB-1];
            dvd_next = old_sum[WB-1] ? (~old_sum + WB'(1)) : old_sum;
            rem_next = '0;
        end else if (cmd.div_step) begin
            rem_next = trial_ge ? trial[CB-1:0] : {rem_reg[CB-2:0], dvd_reg[WB-1]};
            dvd_next = {dvd_reg[WB-2:0], trial_ge};
        end
    end

    always_comb begin
        if (!rd_valid_reg) begin
            avg_value = '0;
        end else if (neg_reg) begin
            avg_value = (dvd_reg > letwa_pkg::QUOT_NEG_LIMIT) ? letwa_pkg::AVG_NEG_SAT
                                                               : ~dvd_reg[15:0] + 16'd1;
        end else begin
            avg_value = (dvd_reg > letwa_pkg::QUOT_POS_LIMIT) ? letwa_pkg::AVG_POS_SAT
                                                               : dvd_reg[15:0];
        end
    end

    assign res_push = (cmd.smp_fire && last_sample) || cmd.avg_push;

    always_comb begin
        res_data = '0;
        if (cmd.avg_push) begin
            res_data.kind           = letwa_pkg::KIND_AVG;
            res_data.average_value  = avg_value;
            res_data.average_valid  = rd_valid_reg;
            res_data.waveforms_seen = count_reg;
        end else begin
            res_data.kind           = letwa_pkg::KIND_TOA;
            res_data.edge_found     = found;
            res_data.arrival_time   = found ? time_f : '0;
            res_data.waveforms_seen = count_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_reg      <= '0;
            avg_len_reg       <= '0;
            length_fixed_reg  <= 1'b0;
            crossing_seen_reg <= 1'b0;
            crossing_time_reg <= '0;
            count_reg         <= '0;
            s1_valid_reg      <= 1'b0;
            fwd_hit_reg       <= 1'b0;
            rd_valid_reg      <= 1'b0;
        end else begin
            position_reg      <= position_next;
            avg_len_reg       <= avg_len_next;
            length_fixed_reg  <= length_fixed_next;
            crossing_seen_reg <= crossing_seen_next;
            crossing_time_reg <= crossing_time_next;
            count_reg         <= count_next;
            s1_valid_reg      <= s1_valid_next;
            fwd_hit_reg       <= fwd_hit_next;
            rd_valid_reg      <= rd_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        s1_first_reg <= !length_fixed_reg;
        s1_addr_reg  <= position_reg[AW-1:0];
        s1_value_reg <= sample_ext;
        fwd_data_reg <= mem_wdata;
        dvd_reg      <= dvd_next;
        rem_reg      <= rem_next;
        neg_reg      <= neg_next;
    end

    a_position_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        position_reg <= POS_MAX)
        else $error("sample position ran past the store depth");

    a_count_needs_length: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != '0 |-> length_fixed_reg && (avg_len_reg != '0))
        else $error("waveforms counted without a fixed averaged length");

endmodule

@@ rtl/leading_edge_toa_and_waveform_averager.sv @@
// Top level of the leading-edge time-of-arrival detector and waveform averager.
//
//  Channel  Direction  Handshake             Carries
//  s_       in         s_valid / s_ready     sample, readout or clear request word
//  m_       out        m_valid / m_ready     time of arrival or average readout word
//  apb      in         psel/penable/pwrite   crossing threshold register
//
// Sample words may arrive back to back while s_ready is high; the sum store is
// updated by a read-modify-write in the cycle after acceptance, with write forwarding.
// A readout word runs one RAM read, a load, 32 steps of the serial divider
// and a push of the result.
// Reset is synchronous; the sum store needs no clearing pass because
// the first waveform after reset or clear overwrites the entries it uses.
// Results go through a two-entry buffer, so s_ready drops only when it is full or
// while a readout is being computed.
module leading_edge_toa_and_waveform_averager #(
    parameter int MAX_SAMPLES = 4096
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    // Configuration port.
    input  logic                                     psel,
    input  logic                                     penable,
    input  logic                                     pwrite,
    input  logic [2:0]                               paddr,
    input  logic [31:0]                              pwdata,
    output logic [31:0]                              prdata,
    output logic                                     pready,
    // Input channel.
    input  logic                                     s_valid,
    output logic                                     s_ready,
    input  logic [letwa_pkg::REQ_BITS-1:0]           s_req_type,
    input  logic signed [letwa_pkg::SAMPLE_BITS-1:0] s_sample_value,
    input  logic [letwa_pkg::TIME_BITS-1:0]          s_sample_time,
    input  logic                                     s_last_sample,
    input  logic [letwa_pkg::INDEX_BITS-1:0]         s_read_index,
    // Result channel.
    output logic                                     m_valid,
    input  logic                                     m_ready,
    output logic                                     m_result_kind,
    output logic                                     m_edge_found,
    output logic [letwa_pkg::TIME_BITS-1:0]          m_arrival_time,
    output logic signed [letwa_pkg::AVG_BITS-1:0]    m_average_value,
    output logic                                     m_average_valid,
    output logic [letwa_pkg::COUNT_BITS-1:0]         m_waveforms_seen
);

    logic signed [letwa_pkg::SAMPLE_BITS-1:0] threshold_reg, threshold_next;
    logic                                     cfg_write;
    letwa_pkg::letwa_cmd_t                    cmd;
    letwa_pkg::letwa_status_t                 status;
    letwa_pkg::letwa_res_t                    res_data, head;
    logic                                     res_push, rbuf_full;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        threshold_next = threshold_reg;
        if (cfg_write && (paddr[2] == letwa_pkg::REG_THRESHOLD)) begin
            threshold_next = pwdata[letwa_pkg::SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= letwa_pkg::THRESH_RESET;
        end else begin
            threshold_reg <= threshold_next;
        end
    end

    assign prdata = (paddr[2] == letwa_pkg::REG_THRESHOLD) ?
                    {{(32 - letwa_pkg::SAMPLE_BITS){threshold_reg[letwa_pkg::SAMPLE_BITS-1]}},
                     threshold_reg} : 32'd0;

    assign status.rbuf_full = rbuf_full;

    letwa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .req_type (s_req_type),
        .status   (status),
        .s_ready  (s_ready),
        .cmd      (cmd)
    );

    letwa_dpath #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_dpath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .threshold    (threshold_reg),
        .sample_value (s_sample_value),
        .sample_time  (s_sample_time),
        .last_sample  (s_last_sample),
        .read_index   (s_read_index),
        .res_push     (res_push),
        .res_data     (res_data)
    );

    letwa_rbuf u_rbuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_push),
        .push_data (res_data),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .head      (head),
        .full      (rbuf_full)
    );

    assign m_result_kind    = head.kind;
    assign m_edge_found     = head.edge_found;
    assign m_arrival_time   = head.arrival_time;
    assign m_average_value  = head.average_value;
    assign m_average_valid  = head.average_valid;
    assign m_waveforms_seen = head.waveforms_seen;

endmodule
